@@ rtl/core/gtf_pkg.sv @@
// Team queue package: payload types, opcodes, status codes, controller states.
// No dependencies.
package gtf_pkg;

    localparam int NumTeamsDef  = 32;
    localparam int MemberIdsDef = 1024;
    localparam int CapacityDef  = 256;

    localparam int MemberW = 10;
    localparam int TeamW   = 5;
    localparam int OpW     = 2;
    localparam int StatusW = 2;

    localparam logic [OpW-1:0] OP_MAP     = 2'd0;
    localparam logic [OpW-1:0] OP_ENQUEUE = 2'd1;
    localparam logic [OpW-1:0] OP_DEQUEUE = 2'd2;
    localparam logic [OpW-1:0] OP_NOP     = 2'd3;

    localparam logic [StatusW-1:0] ST_DONE     = 2'd0;
    localparam logic [StatusW-1:0] ST_DEQUEUED = 2'd1;
    localparam logic [StatusW-1:0] ST_EMPTY    = 2'd2;
    localparam logic [StatusW-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [OpW-1:0]     opcode;
        logic [MemberW-1:0] member;
        logic [TeamW-1:0]   team_id;
    } t_req;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [MemberW-1:0] out_member;
    } t_rsp;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic init_step;
        logic load;
        logic read;
        logic exec;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic init_done;
    } t_sts;

endpackage

@@ rtl/core/gtf_ctrl.sv @@
// Team queue controller: init sweep, then read/exec/output per request.
// Depends on gtf_pkg.
module gtf_ctrl
    import gtf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.init_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                o_ready = i_ready;
                if (i_ready) begin
                    if (i_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_INIT;
        endcase
    end

endmodule

@@ rtl/core/gtf_dp.sv @@
// Team queue datapath: team table, team ring, list store, free stack.
// Depends on gtf_pkg.
module gtf_dp
    import gtf_pkg::*;
#(
    parameter int NUM_TEAMS  = NumTeamsDef,
    parameter int MEMBER_IDS = MemberIdsDef,
    parameter int CAPACITY   = CapacityDef
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  t_req i_req,
    output t_rsp o_rsp
);

    localparam int TW    = (NUM_TEAMS > 1) ? $clog2(NUM_TEAMS) : 1;
    localparam int MW    = (MEMBER_IDS > 1) ? $clog2(MEMBER_IDS) : 1;
    localparam int EW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int OCW   = $clog2(NUM_TEAMS + 1);
    localparam int SW    = (MW > EW) ? MW : EW;
    localparam int SWEEP = (MEMBER_IDS > CAPACITY) ? MEMBER_IDS : CAPACITY;

    logic [TW-1:0]      team_mem  [MEMBER_IDS];
    logic [TW-1:0]      ring_mem  [NUM_TEAMS];
    logic [EW-1:0]      first_mem [NUM_TEAMS];
    logic [EW-1:0]      last_mem  [NUM_TEAMS];
    logic [MemberW-1:0] emem_mem  [CAPACITY];
    logic [EW-1:0]      link_mem  [CAPACITY];
    logic [EW-1:0]      free_mem  [CAPACITY];

    logic [NUM_TEAMS-1:0] r_waiting;
    logic [TW-1:0]        r_head, r_tail;
    logic [OCW-1:0]       r_ocount;
    logic [CW-1:0]        r_fcount;
    logic [SW:0]          r_sweep;

    t_req r_req;
    t_rsp r_rsp;

    logic [TW-1:0]      r_mteam, r_rteam;
    logic [EW-1:0]      r_free_e;
    logic [EW-1:0]      r_first, r_last, r_link;
    logic [MemberW-1:0] r_emem;

    logic in_member;
    logic team_ok;
    assign in_member = (int'(r_req.member) < MEMBER_IDS);
    assign team_ok   = (int'(r_req.team_id) < NUM_TEAMS);

    assign o_sts.init_done = (r_sweep == (SW + 1)'(SWEEP - 1));

    function automatic logic [TW-1:0] ring_next(input logic [TW-1:0] p);
        return ({1'b0, p} + 1'b1 >= (TW + 1)'(NUM_TEAMS)) ? '0 : p + 1'b1;
    endfunction

    // front team of the ring and its first entry
    logic [TW-1:0] head_team;
    logic [EW-1:0] head_e;
    assign head_team = ring_mem[r_head];
    assign head_e    = first_mem[head_team];

    // team of the latched member for enqueue
    logic [TW-1:0] eq_team;
    assign eq_team = (in_member && int'(r_mteam) < NUM_TEAMS) ? r_mteam : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep  <= '0;
            r_waiting <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_ocount <= '0;
            r_fcount <= CW'(CAPACITY);
        end else begin
            if (i_cmd.init_step) begin
                if (r_sweep < (SW + 1)'(MEMBER_IDS)) begin
                    team_mem[MW'(r_sweep)] <= '0;
                end
                if (r_sweep < (SW + 1)'(CAPACITY)) begin
                    free_mem[r_sweep[EW-1:0]] <= r_sweep[EW-1:0];
                end
                if (!o_sts.init_done) begin
                    r_sweep <= r_sweep + 1'b1;
                end
            end
            if (i_cmd.load) begin
                r_req <= i_req;
            end
            if (i_cmd.read) begin
                // member team, front of the front team, free top
                r_mteam <= team_mem[MW'(r_req.member)];
                r_rteam <= head_team;
                r_first <= head_e;
                r_last  <= last_mem[head_team];
                r_emem  <= emem_mem[head_e];
                r_link  <= link_mem[head_e];
                if (r_fcount != '0) begin
                    r_free_e <= free_mem[EW'(r_fcount - 1'b1)];
                end
            end
            if (i_cmd.exec) begin
                unique case (r_req.opcode)
                    OP_MAP: begin
                        r_rsp <= '{status: ST_DONE, out_member: '0};
                        if (in_member && team_ok) begin
                            team_mem[MW'(r_req.member)] <= TW'(r_req.team_id);
                        end
                    end
                    OP_ENQUEUE: begin
                        if (r_fcount == '0) begin
                            r_rsp <= '{status: ST_FULL, out_member: '0};
                        end else begin
                            r_rsp <= '{status: ST_DONE, out_member: '0};
                            r_fcount <= r_fcount - 1'b1;
                            emem_mem[r_free_e] <= r_req.member;
                            if (r_waiting[eq_team]) begin
                                link_mem[last_mem[eq_team]] <= r_free_e;
                                last_mem[eq_team] <= r_free_e;
                            end else begin
                                r_waiting[eq_team] <= 1'b1;
                                first_mem[eq_team] <= r_free_e;
                                last_mem[eq_team]  <= r_free_e;
                                ring_mem[r_tail] <= eq_team;
                                r_tail   <= ring_next(r_tail);
                                r_ocount <= r_ocount + 1'b1;
                            end
                        end
                    end
                    OP_DEQUEUE: begin
                        if (r_ocount == '0) begin
                            r_rsp <= '{status: ST_EMPTY, out_member: '0};
                        end else begin
                            r_rsp <= '{status: ST_DEQUEUED, out_member: r_emem};
                            if (r_first == r_last) begin
                                r_waiting[r_rteam] <= 1'b0;
                                r_head   <= ring_next(r_head);
                                r_ocount <= r_ocount - 1'b1;
                            end else begin
                                first_mem[r_rteam] <= r_link;
                            end
                            free_mem[EW'(r_fcount)] <= r_first;
                            r_fcount <= r_fcount + 1'b1;
                        end
                    end
                    default: r_rsp <= '{status: ST_DONE, out_member: '0};
                endcase
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule

@@ rtl/core/grouped_team_fifo_top.sv @@
// Team queue top level: controller plus datapath.
// Depends on gtf_pkg, gtf_ctrl, gtf_dp.
//
// Usage: requests arrive on i_req (valid/ready); each gives exactly one
// response on o_rsp (valid/ready). Opcode map assigns a member to a team,
// enqueue appends a member behind its team, dequeue returns the front
// member of the front team.
// Steps: an accepted request is latched (load), the tables are read (read),
// then the operation is executed and the response registered (exec). The
// response can be taken together with the next request; a new request is
// taken only once the previous response is taken, as these steps share the table memories.
// Reset: synchronous, active low. After reset the member-to-team table is
// cleared and the free stack loaded by a sweep over max(MEMBER_IDS,
// CAPACITY) entries, during which o_req_ready stays low.
// Stall: while o_rsp_valid waits for i_rsp_ready the response holds and
// no new request is taken.
module grouped_team_fifo_top
    import gtf_pkg::*;
#(
    parameter int NUM_TEAMS  = NumTeamsDef,
    parameter int MEMBER_IDS = MemberIdsDef,
    parameter int CAPACITY   = CapacityDef
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_cmd cmd;
    t_sts sts;

    gtf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req_valid),
        .o_ready (o_req_ready),
        .o_valid (o_rsp_valid),
        .i_ready (i_rsp_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    gtf_dp #(
        .NUM_TEAMS  (NUM_TEAMS),
        .MEMBER_IDS (MEMBER_IDS),
        .CAPACITY   (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.init_step, cmd.load, cmd.read, cmd.exec}))
        else $error("overlapping controller commands");

    a_load_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.read)
        else $error("read step did not follow accept");

    a_rsp_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status != ST_DEQUEUED) |-> o_rsp.out_member == '0)
        else $error("member reported without dequeue");

endmodule
